### hdl/median3x3_rgb_filter_core_defines.svh
// assertion macros shared by the median filter core
`ifndef MEDIAN3X3_RGB_FILTER_CORE_DEFINES_SVH
`define MEDIAN3X3_RGB_FILTER_CORE_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define M3F_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define M3F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/m3f_pkg.sv
// shared types, constants and helper functions of the median filter core
package m3f_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WU_W       = $clog2(MAX_WIDTH + 1);
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CMP_W      = (WU_W > CFG_WIDTH_W) ? WU_W : CFG_WIDTH_W;
  localparam int CNT_W      = 22;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int ROWS       = 3;
  localparam int BANK_W     = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [COL_W-1:0]        col_t;
  typedef logic [WU_W-1:0]         wu_t;
  typedef logic [CMP_W-1:0]        cmp_t;
  typedef logic [CFG_WIDTH_W-1:0]  cfg_width_t;
  typedef logic [CFG_HEIGHT_W-1:0] row_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [BANK_W-1:0]       bank_t;
  typedef logic [FIFO_AW-1:0]      fptr_t;
  typedef logic [FIFO_AW:0]        fcnt_t;

  localparam cfg_width_t RESET_WIDTH  = cfg_width_t'(640);
  localparam row_t       RESET_HEIGHT = row_t'(480);

  // register indexes of the config port
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // item kinds
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  // one queue entry: optional line write, optional column read, optional result
  typedef struct packed {
    logic  we;
    bank_t wbank;
    col_t  wcol;
    pix_t  wdata;
    logic  rd;
    bank_t rbank;
    col_t  rcol;
    logic  emit;
    logic  border;
    logic  last;
  } job_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    fcnt_t count;
  } fifo_stat_t;

  // one window column, rows above, at and below the center row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col3_t;

  typedef struct packed {
    chan_t lo;
    chan_t md;
    chan_t hi;
  } trio_t;

  function automatic bank_t bank_inc(input bank_t b);
    return (b == bank_t'(ROWS - 1)) ? bank_t'(0) : b + bank_t'(1);
  endfunction

  function automatic bank_t bank_dec(input bank_t b);
    return (b == bank_t'(0)) ? bank_t'(ROWS - 1) : b - bank_t'(1);
  endfunction

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(input chan_t a, input chan_t b, input chan_t c);
    trio_t s;
    s.lo = min2(min2(a, b), c);
    s.md = med3(a, b, c);
    s.hi = max2(max2(a, b), c);
    return s;
  endfunction

endpackage

### hdl/m3f_front.sv
// front end: config registers, frame counters and item classification
module m3f_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  m3f_pkg::cfg_data_t  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  m3f_pkg::pix_t       in_pix,
  input  m3f_pkg::fifo_stat_t fifo_stat,
  output logic                push,
  output m3f_pkg::job_t       job
);

  m3f_pkg::cfg_width_t cfg_width_r;
  m3f_pkg::row_t       cfg_height_r;
  logic                hold_r;
  m3f_pkg::cnt_t       total_r, total_nxt;
  m3f_pkg::cnt_t       taken_r, taken_nxt, given_r, given_nxt;
  m3f_pkg::col_t       tcol_r, tcol_nxt, pcol_r, pcol_nxt;
  m3f_pkg::bank_t      tbank_r, tbank_nxt, pbank_r, pbank_nxt;
  m3f_pkg::row_t       prow_r, prow_nxt;

  m3f_pkg::cmp_t  wx;
  m3f_pkg::wu_t   wu;
  m3f_pkg::row_t  hu;
  logic           acc, clr, emit_c, p_end;
  m3f_pkg::cnt_t  t, g;
  m3f_pkg::col_t  tc, pc;
  m3f_pkg::bank_t tb, pb;
  m3f_pkg::row_t  pr;

  always_comb begin
    wx = m3f_pkg::cmp_t'(cfg_width_r);
    if (wx < m3f_pkg::cmp_t'(3)) begin
      wu = m3f_pkg::wu_t'(3);
    end else if (wx > m3f_pkg::cmp_t'(m3f_pkg::MAX_WIDTH)) begin
      wu = m3f_pkg::wu_t'(m3f_pkg::MAX_WIDTH);
    end else begin
      wu = m3f_pkg::wu_t'(wx);
    end
    hu = (cfg_height_r < m3f_pkg::row_t'(3)) ? m3f_pkg::row_t'(3) : cfg_height_r;
  end

  assign total_nxt = m3f_pkg::cnt_t'(m3f_pkg::cnt_t'(wu) * m3f_pkg::cnt_t'(hu));

  assign in_stall = fifo_stat.full || hold_r;
  assign acc      = in_valid && !in_stall;

  // a frame left over from larger sizes is closed before the item
  assign clr = (given_r >= total_r) || (taken_r > total_r);
  assign t   = clr ? '0 : taken_r;
  assign g   = clr ? '0 : given_r;
  assign tc  = clr ? '0 : tcol_r;
  assign tb  = clr ? '0 : tbank_r;
  assign pc  = clr ? '0 : pcol_r;
  assign pb  = clr ? '0 : pbank_r;
  assign pr  = clr ? '0 : prow_r;
  assign p_end = (m3f_pkg::wu_t'(pc) == wu - m3f_pkg::wu_t'(1));

  always_comb begin
    taken_nxt = taken_r;
    given_nxt = given_r;
    tcol_nxt  = tcol_r;
    tbank_nxt = tbank_r;
    pcol_nxt  = pcol_r;
    pbank_nxt = pbank_r;
    prow_nxt  = prow_r;
    job       = '0;
    emit_c    = 1'b0;
    if (acc) begin
      taken_nxt = t;
      given_nxt = g;
      tcol_nxt  = tc;
      tbank_nxt = tb;
      pcol_nxt  = pc;
      pbank_nxt = pb;
      prow_nxt  = pr;
      if (in_action == m3f_pkg::ACT_PIXEL) begin
        if (t < total_r) begin
          job.we    = 1'b1;
          job.wbank = tb;
          job.wcol  = tc;
          job.wdata = in_pix;
          // first pixel of a frame also preloads the window's first column
          if (t == '0) begin
            job.rd    = 1'b1;
            job.rbank = tb;
            job.rcol  = tc;
          end
          taken_nxt = t + m3f_pkg::cnt_t'(1);
          if (m3f_pkg::wu_t'(tc) == wu - m3f_pkg::wu_t'(1)) begin
            tcol_nxt  = '0;
            tbank_nxt = m3f_pkg::bank_inc(tb);
          end else begin
            tcol_nxt = tc + m3f_pkg::col_t'(1);
          end
          emit_c = (t + m3f_pkg::cnt_t'(1) - g) >=
                   (m3f_pkg::cnt_t'(wu) + m3f_pkg::cnt_t'(2));
        end
      end else begin
        emit_c = (t >= total_r) && (g < t);
      end
      if (emit_c) begin
        job.rd     = 1'b1;
        job.emit   = 1'b1;
        job.last   = (g + m3f_pkg::cnt_t'(1)) == total_r;
        job.border = (pr == '0) || (pr >= hu - m3f_pkg::row_t'(1)) || (pc == '0) || p_end;
        // end of row fetches column zero of the next row's window
        if (p_end) begin
          job.rcol  = '0;
          job.rbank = m3f_pkg::bank_inc(pb);
        end else begin
          job.rcol  = pc + m3f_pkg::col_t'(1);
          job.rbank = pb;
        end
        if ((g + m3f_pkg::cnt_t'(1)) >= total_r) begin
          given_nxt = '0;
          taken_nxt = '0;
          tcol_nxt  = '0;
          tbank_nxt = '0;
          pcol_nxt  = '0;
          pbank_nxt = '0;
          prow_nxt  = '0;
        end else begin
          given_nxt = g + m3f_pkg::cnt_t'(1);
          if (p_end) begin
            pcol_nxt  = '0;
            prow_nxt  = pr + m3f_pkg::row_t'(1);
            pbank_nxt = m3f_pkg::bank_inc(pb);
          end else begin
            pcol_nxt = pc + m3f_pkg::col_t'(1);
          end
        end
      end
    end
  end

  assign push = acc && (job.we || job.rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= m3f_pkg::RESET_WIDTH;
      cfg_height_r <= m3f_pkg::RESET_HEIGHT;
      hold_r       <= 1'b0;
      total_r      <= m3f_pkg::cnt_t'(m3f_pkg::cnt_t'(m3f_pkg::RESET_WIDTH) *
                                      m3f_pkg::cnt_t'(m3f_pkg::RESET_HEIGHT));
      taken_r      <= '0;
      given_r      <= '0;
      tcol_r       <= '0;
      tbank_r      <= '0;
      pcol_r       <= '0;
      pbank_r      <= '0;
      prow_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == m3f_pkg::CFG_IDX_WIDTH) begin
          cfg_width_r <= cfg_wdata[m3f_pkg::CFG_WIDTH_W-1:0];
        end else begin
          cfg_height_r <= cfg_wdata[m3f_pkg::CFG_HEIGHT_W-1:0];
        end
      end
      // frame size product is registered from the size registers, and input is held while it settles after a write
      hold_r  <= cfg_we;
      total_r <= total_nxt;
      taken_r <= taken_nxt;
      given_r <= given_nxt;
      tcol_r  <= tcol_nxt;
      tbank_r <= tbank_nxt;
      pcol_r  <= pcol_nxt;
      pbank_r <= pbank_nxt;
      prow_r  <= prow_nxt;
    end
  end

endmodule

### hdl/m3f_fifo.sv
// short queue of jobs between front end and back end
module m3f_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  m3f_pkg::job_t       push_job,
  input  logic                pop,
  output m3f_pkg::job_t       head,
  output m3f_pkg::fifo_stat_t stat
);

  m3f_pkg::job_t  mem_r [m3f_pkg::FIFO_DEPTH];
  m3f_pkg::fptr_t wptr_r, rptr_r;
  m3f_pkg::fcnt_t cnt_r;

  assign head       = mem_r[rptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == m3f_pkg::fcnt_t'(m3f_pkg::FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + m3f_pkg::fptr_t'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + m3f_pkg::fptr_t'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + m3f_pkg::fcnt_t'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - m3f_pkg::fcnt_t'(1);
      end
    end
  end

endmodule

### hdl/m3f_back.sv
// back end: line memory, 3x3 window and pipelined per-channel median
module m3f_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  m3f_pkg::job_t       head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output m3f_pkg::pix_t       out_pix,
  output logic                out_last
);

  logic move;

  // read stage
  m3f_pkg::pix_t  wd1_r;
  logic           v1_r, rd1_r, emit1_r, border1_r, last1_r;
  m3f_pkg::bank_t rbank1_r;
  m3f_pkg::pix_t  db [m3f_pkg::ROWS];
  m3f_pkg::col3_t colv;

  // window stage
  m3f_pkg::col3_t win_r [3];
  logic           v2_r, border2_r, last2_r;

  // sorted columns
  m3f_pkg::trio_t [2:0][2:0] srt_r;
  m3f_pkg::pix_t  ctr3_r;
  logic           v3_r, border3_r, last3_r;

  // low, middle and high candidates
  m3f_pkg::trio_t [2:0] cand_r;
  m3f_pkg::pix_t  ctr4_r;
  logic           v4_r, border4_r, last4_r;

  logic           out_valid_r, out_last_r;
  m3f_pkg::pix_t  out_pix_r;

  assign move = !out_valid_r || !out_stall;
  assign pop  = move && job_valid;

  for (genvar b = 0; b < m3f_pkg::ROWS; b++) begin : g_bank
    m3f_pkg::pix_t mem [m3f_pkg::MAX_WIDTH];
    m3f_pkg::pix_t rdat_r;
    logic          fwd_r;
    always_ff @(posedge clk) begin
      if (pop && head.we && (head.wbank == m3f_pkg::bank_t'(b))) begin
        mem[head.wcol] <= head.wdata;
      end
      if (pop && head.rd) begin
        rdat_r <= mem[head.rcol];
        // the entry may read the pixel it writes in the same cycle
        fwd_r  <= head.we && (head.wbank == m3f_pkg::bank_t'(b)) &&
                  (head.wcol == head.rcol);
      end
    end
    assign db[b] = fwd_r ? wd1_r : rdat_r;
  end

  assign colv.top = db[m3f_pkg::bank_dec(rbank1_r)];
  assign colv.mid = db[rbank1_r];
  assign colv.bot = db[m3f_pkg::bank_inc(rbank1_r)];

  always_ff @(posedge clk) begin
    if (move) begin
      if (pop) begin
        wd1_r     <= head.wdata;
        rd1_r     <= head.rd;
        emit1_r   <= head.emit;
        border1_r <= head.border;
        last1_r   <= head.last;
        rbank1_r  <= head.rbank;
      end
      if (v1_r && rd1_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= colv;
      end
      border2_r <= border1_r;
      last2_r   <= last1_r;
      for (int k = 0; k < 3; k++) begin
        for (int ch = 0; ch < 3; ch++) begin
          srt_r[k][ch] <= m3f_pkg::sort3(win_r[k].top[ch*m3f_pkg::CH_W +: m3f_pkg::CH_W],
                                         win_r[k].mid[ch*m3f_pkg::CH_W +: m3f_pkg::CH_W],
                                         win_r[k].bot[ch*m3f_pkg::CH_W +: m3f_pkg::CH_W]);
        end
      end
      ctr3_r    <= win_r[1].mid;
      border3_r <= border2_r;
      last3_r   <= last2_r;
      for (int ch = 0; ch < 3; ch++) begin
        cand_r[ch].lo <= m3f_pkg::max2(m3f_pkg::max2(srt_r[0][ch].lo, srt_r[1][ch].lo),
                                       srt_r[2][ch].lo);
        cand_r[ch].md <= m3f_pkg::med3(srt_r[0][ch].md, srt_r[1][ch].md, srt_r[2][ch].md);
        cand_r[ch].hi <= m3f_pkg::min2(m3f_pkg::min2(srt_r[0][ch].hi, srt_r[1][ch].hi),
                                       srt_r[2][ch].hi);
      end
      ctr4_r    <= ctr3_r;
      border4_r <= border3_r;
      last4_r   <= last3_r;
      for (int ch = 0; ch < 3; ch++) begin
        out_pix_r[ch*m3f_pkg::CH_W +: m3f_pkg::CH_W] <= border4_r ?
          ctr4_r[ch*m3f_pkg::CH_W +: m3f_pkg::CH_W] :
          m3f_pkg::med3(cand_r[ch].lo, cand_r[ch].md, cand_r[ch].hi);
      end
      out_last_r <= last4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (move) begin
      v1_r        <= pop;
      v2_r        <= v1_r && emit1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

endmodule

### hdl/median3x3_rgb_filter_core.sv
// top level of the streaming 3x3 per-channel median filter
// a result passes the job queue and the read, window, sort, candidate and output stages
// throughput: one item per cycle unless stalled, one read of three line banks per item
// a four-entry job queue lets the front take items while the result pipeline is stalled
// reset: frame counters clear, sizes return to 640 x 480; line memory keeps its contents
`include "median3x3_rgb_filter_core_defines.svh"

module median3x3_rgb_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [m3f_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_frame_last
);

  m3f_pkg::fifo_stat_t fifo_stat;
  m3f_pkg::job_t       push_job, head;
  m3f_pkg::pix_t       in_pix, out_pix;
  logic                push, back_pop;

  assign in_pix = {in_red, in_green, in_blue};

  m3f_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_pix    (in_pix),
    .fifo_stat (fifo_stat),
    .push      (push),
    .job       (push_job)
  );

  m3f_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (back_pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  m3f_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!fifo_stat.empty),
    .head      (head),
    .pop       (back_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pix   (out_pix),
    .out_last  (out_frame_last)
  );

  assign out_red   = out_pix[23:16];
  assign out_green = out_pix[15:8];
  assign out_blue  = out_pix[7:0];

  `M3F_ASSERT_NOW(a_full_stalls, fifo_stat.full, in_stall, "input open while job queue full")
  `M3F_ASSERT_NEXT(a_cfg_holds, cfg_we, in_stall, "input open right after config write")
  `M3F_ASSERT_NOW(a_pop_nonempty, back_pop, !fifo_stat.empty, "job popped from empty queue")
  `M3F_ASSERT_NOW(a_cnt_range, 1'b1, fifo_stat.count <= m3f_pkg::fcnt_t'(m3f_pkg::FIFO_DEPTH), "job queue count overflow")

endmodule
